// ----- src/ebac_pkg.sv -----
// Shared types and constants for the eight-bit accumulator processor.
// No dependencies; used by ebac_core and eight_bit_accumulator_cpu_top.
`timescale 1ns / 1ps
`default_nettype none

package ebac_pkg;

  // Geometry
  localparam int MEM_WORDS   = 32;
  localparam int PHASE_TICKS = 8;
  localparam int MEM_AW      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int TICK_W      = (PHASE_TICKS > 1) ? $clog2(PHASE_TICKS) : 1;

  // Field widths fixed by the interface
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 8;
  localparam int START_W = 6;

  // Memory bound, widened by one bit so it compares against a 5-bit address
  localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_WORDS);
  localparam logic [TICK_W-1:0] LAST_TICK = TICK_W'(PHASE_TICKS - 1);

  // Reset value of the store-protection boundary
  localparam logic [START_W-1:0] RAM_START_RST = 6'd16;

  // Input item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Phase codes as seen on the result item
  localparam logic [1:0] PH_CODE_FETCH = 2'd0;
  localparam logic [1:0] PH_CODE_EXEC  = 2'd1;
  localparam logic [1:0] PH_CODE_HALT  = 2'd2;

  // Sequencer phase, one-hot
  typedef enum logic [2:0] {
    PH_FETCH = 3'b001,
    PH_EXEC  = 3'b010,
    PH_HALT  = 3'b100
  } phase_e;

  // Major opcode, instruction bits 7..5
  typedef enum logic [2:0] {
    OP_LDA = 3'd0,
    OP_STA = 3'd1,
    OP_ADD = 3'd2,
    OP_SUB = 3'd3,
    OP_JMP = 3'd4,
    OP_JOM = 3'd5,
    OP_JOZ = 3'd6,
    OP_OPR = 3'd7
  } op_e;

  // Operate group, instruction bits 2..0
  typedef enum logic [2:0] {
    SUB_RAB = 3'd0,
    SUB_SHA = 3'd1,
    SUB_AND = 3'd2,
    SUB_DCA = 3'd3,
    SUB_CMA = 3'd4,
    SUB_NOP = 3'd5,
    SUB_RAE = 3'd6,
    SUB_HLT = 3'd7
  } sub_e;

  // Architectural processor state
  typedef struct packed {
    phase_e              phase;
    logic [TICK_W-1:0]   tick;
    logic [ADDR_W-1:0]   pc;
    logic [DATA_W-1:0]   instr;
    logic [DATA_W-1:0]   acc;
    logic [DATA_W-1:0]   reg_b;
    logic [DATA_W-1:0]   reg_e;
  } cpu_state_t;

  // Memory write request
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  // One-hot phase to result code
  function automatic logic [1:0] phase_code(phase_e ph);
    logic [1:0] code;
    case (ph)
      PH_FETCH: code = PH_CODE_FETCH;
      PH_EXEC:  code = PH_CODE_EXEC;
      PH_HALT:  code = PH_CODE_HALT;
      default:  code = PH_CODE_FETCH;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- src/eight_bit_accumulator_cpu_top.sv -----
// Top level of the eight-bit accumulator processor: stream ports, state,
// 32-byte memory and result register. Depends on ebac_pkg and ebac_core.
`timescale 1ns / 1ps
`default_nettype none

// Each input item is either a clock tick (tuser 0) or a memory byte load
// (tuser 1), and yields exactly one result item holding phase, accumulator,
// program counter and tick position after that item. The whole tick,
// including the single memory read of the fetch or execute step, is done
// in combinational logic between the state registers and the result
// register, so an item is accepted every cycle while the result register is
// empty or being drained. Memory is a 32-byte register file cleared by
// reset. The store boundary (cfg_wdata_i) resets to 16; the user writes it
// with cfg_we_i only while the block is idle; the block does not enforce this.
module eight_bit_accumulator_cpu_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: store boundary
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  // Input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [4:0] load_address, [12:5] load_data
  input  wire logic [0:0]  s_axis_tuser,  // [0] opcode
  // Result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // [1:0] phase, [9:2] acc_value,
                                          // [14:10] pc_value, [17:15] tick_count
);

  ebac_pkg::cpu_state_t            state_q, state_d;
  ebac_pkg::mem_wr_t               mem_wr;
  logic [ebac_pkg::DATA_W-1:0]     mem_q [ebac_pkg::MEM_WORDS];
  logic [ebac_pkg::ADDR_W-1:0]     rd_addr;
  logic [ebac_pkg::DATA_W-1:0]     rd_data;
  logic [ebac_pkg::START_W-1:0]    ram_start_q;
  logic                            m_valid_q;
  logic [23:0]                     m_data_q, m_data_d;
  logic                            accept;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Memory read, zero beyond the implemented words
  assign rd_data = ({1'b0, rd_addr} < ebac_pkg::MEM_LIMIT) ?
                   mem_q[rd_addr[ebac_pkg::MEM_AW-1:0]] : '0;

  ebac_core u_core (
    .cur_i       (state_q),
    .kind_i      (s_axis_tuser[0]),
    .load_addr_i (s_axis_tdata[4:0]),
    .load_data_i (s_axis_tdata[12:5]),
    .ram_start_i (ram_start_q),
    .nxt_o       (state_d),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .mem_wr_o    (mem_wr)
  );

  // Result packing from the state after the item
  assign m_data_d = {6'd0, state_d.tick, state_d.pc, state_d.acc,
                     ebac_pkg::phase_code(state_d.phase)};

  // Store boundary register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_start_q <= ebac_pkg::RAM_START_RST;
    end else if (cfg_we_i) begin
      ram_start_q <= cfg_wdata_i;
    end
  end

  // Processor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= ebac_pkg::PH_FETCH;
      state_q.tick  <= '0;
      state_q.pc    <= '0;
      state_q.instr <= '0;
      state_q.acc   <= '0;
      state_q.reg_b <= '0;
      state_q.reg_e <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Byte memory, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ebac_pkg::MEM_WORDS; i++) begin
        mem_q[i] <= '0;
      end
    end else if (accept && mem_wr.en) begin
      mem_q[mem_wr.addr] <= mem_wr.data;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= m_data_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/ebac_core.sv -----
// Next-state logic of the accumulator processor for one input item.
// Depends on ebac_pkg; memory storage lives in the top level.
`timescale 1ns / 1ps
`default_nettype none

module ebac_core (
  input  wire ebac_pkg::cpu_state_t            cur_i,
  input  wire logic                            kind_i,
  input  wire logic [ebac_pkg::ADDR_W-1:0]     load_addr_i,
  input  wire logic [ebac_pkg::DATA_W-1:0]     load_data_i,
  input  wire logic [ebac_pkg::START_W-1:0]    ram_start_i,
  output ebac_pkg::cpu_state_t                 nxt_o,
  output logic [ebac_pkg::ADDR_W-1:0]          rd_addr_o,
  input  wire logic [ebac_pkg::DATA_W-1:0]     rd_data_i,
  output ebac_pkg::mem_wr_t                    mem_wr_o
);

  logic [ebac_pkg::ADDR_W-1:0] opnd;
  logic [ebac_pkg::ADDR_W:0]   pc_inc;
  logic                        last;

  assign opnd   = cur_i.instr[ebac_pkg::ADDR_W-1:0];
  assign pc_inc = {1'b0, cur_i.pc} + 6'd1;
  assign last   = (cur_i.tick == ebac_pkg::LAST_TICK);

  // Fetch reads at the program counter, execute at the operand address
  assign rd_addr_o = (cur_i.phase == ebac_pkg::PH_FETCH) ? cur_i.pc : opnd;

  always_comb begin
    nxt_o    = cur_i;
    mem_wr_o = '0;
    if (kind_i == ebac_pkg::KIND_LOAD) begin
      // Memory load, allowed in any phase; clock does not advance
      mem_wr_o.en   = ({1'b0, load_addr_i} < ebac_pkg::MEM_LIMIT);
      mem_wr_o.addr = load_addr_i[ebac_pkg::MEM_AW-1:0];
      mem_wr_o.data = load_data_i;
    end else if (cur_i.phase != ebac_pkg::PH_HALT) begin
      if (cur_i.phase == ebac_pkg::PH_FETCH) begin
        nxt_o.instr = rd_data_i;
      end else if (last) begin
        // Instruction runs on the last execute tick
        case (ebac_pkg::op_e'(cur_i.instr[7:5]))
          ebac_pkg::OP_LDA: nxt_o.acc = rd_data_i;
          ebac_pkg::OP_STA: begin
            mem_wr_o.en   = ({1'b0, opnd} >= ram_start_i) &&
                            ({1'b0, opnd} < ebac_pkg::MEM_LIMIT);
            mem_wr_o.addr = opnd[ebac_pkg::MEM_AW-1:0];
            mem_wr_o.data = cur_i.acc;
          end
          ebac_pkg::OP_ADD: nxt_o.acc = cur_i.acc + rd_data_i;
          ebac_pkg::OP_SUB: nxt_o.acc = cur_i.acc - rd_data_i;
          ebac_pkg::OP_JMP: nxt_o.pc  = opnd;
          ebac_pkg::OP_JOM: if (cur_i.acc[7]) nxt_o.pc = opnd;
          ebac_pkg::OP_JOZ: if (cur_i.acc == 8'd0) nxt_o.pc = opnd;
          ebac_pkg::OP_OPR: begin
            case (ebac_pkg::sub_e'(cur_i.instr[2:0]))
              ebac_pkg::SUB_RAB: begin
                nxt_o.acc   = cur_i.reg_b;
                nxt_o.reg_b = cur_i.acc;
              end
              ebac_pkg::SUB_SHA: begin
                // Operand bit 4 picks the direction
                if (opnd[4]) nxt_o.acc = {cur_i.acc[6:0], 1'b0};
                else         nxt_o.acc = {1'b0, cur_i.acc[7:1]};
              end
              ebac_pkg::SUB_AND: nxt_o.acc = cur_i.acc & cur_i.reg_b;
              ebac_pkg::SUB_DCA: nxt_o.acc = cur_i.acc - 8'd1;
              ebac_pkg::SUB_CMA: nxt_o.acc = ~cur_i.acc;
              ebac_pkg::SUB_NOP: nxt_o.acc = cur_i.acc;
              ebac_pkg::SUB_RAE: begin
                nxt_o.acc   = cur_i.reg_e;
                nxt_o.reg_e = cur_i.acc;
              end
              ebac_pkg::SUB_HLT: nxt_o.phase = ebac_pkg::PH_HALT;
              default: nxt_o.acc = cur_i.acc;
            endcase
          end
          default: nxt_o.acc = cur_i.acc;
        endcase
      end

      // Tick counter and phase sequencing
      if (last) begin
        nxt_o.tick = '0;
        if (cur_i.phase == ebac_pkg::PH_FETCH) begin
          nxt_o.phase = ebac_pkg::PH_EXEC;
          nxt_o.pc    = (pc_inc >= ebac_pkg::MEM_LIMIT) ? '0 : pc_inc[ebac_pkg::ADDR_W-1:0];
        end else if (nxt_o.phase == ebac_pkg::PH_EXEC) begin
          nxt_o.phase = ebac_pkg::PH_FETCH;
        end
      end else begin
        nxt_o.tick = cur_i.tick + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
